### hdl/gtsa_pkg.sv
package gtsa_pkg;

  localparam int unsigned SLOTS_DEF    = 128;
  localparam int unsigned KEY_BITS_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADKEY = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_in;
    logic [63:0] handler_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [63:0] handler_out;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic find;
    logic pick;
    logic exec;
  } gtsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_create;
    logic grp_found;
  } gtsa_sts_t;

endpackage

### hdl/gtsa_ctrl.sv
module gtsa_ctrl
  import gtsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gtsa_sts_t sts,
  output gtsa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ROW,
    S_PICK,
    S_SLOT,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;

  // result register can take a new word when empty or being drained
  assign fire = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.is_create ? S_FIND : S_SLOT;
        end
      end
      S_FIND: state_nxt = sts.grp_found ? S_ROW : S_EXEC;
      S_ROW:  state_nxt = S_PICK;
      S_PICK: state_nxt = S_SLOT;
      S_SLOT: state_nxt = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.find = (state_r == S_FIND);
  assign cmd.pick = (state_r == S_PICK);
  assign cmd.exec = fire;

  a_word_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word raised outside execute");

  a_pick_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> ($past(state_r) == S_ROW))
    else $error("slot pick without row read");

  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.load)
    else $error("input latched while busy");

endmodule

### hdl/gtsa_dp.sv
module gtsa_dp
  import gtsa_pkg::*;
#(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  gtsa_cmd_t cmd,
  output gtsa_sts_t sts,
  output out_word_t out_data
);

  // slot index = {group, bit}; groups hold the in-use and touched rows
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned GIDX_W = IDX_W / 2;
  localparam int unsigned BIT_W  = IDX_W - GIDX_W;
  localparam int unsigned GSEL_W = (GIDX_W > 0) ? GIDX_W : 1;
  localparam int unsigned NGRP   = 1 << GIDX_W;
  localparam int unsigned GRP_W  = 1 << BIT_W;
  localparam int unsigned GEN_W  = KEY_BITS - IDX_W;
  localparam int unsigned CMP_W  = (KEY_BITS > 32) ? KEY_BITS : 32;

  logic [1:0]       op_r;
  logic [31:0]      key_r;
  logic [63:0]      hdl_r;
  logic [IDX_W-1:0] idx_r;
  logic             found_r;

  logic [GRP_W-1:0] used_mem  [NGRP];
  logic [GRP_W-1:0] touch_mem [NGRP];
  logic [GEN_W-1:0] gen_mem   [SLOTS];
  logic [63:0]      hdl_mem   [SLOTS];

  logic [NGRP-1:0]  row_vld_r;
  logic [NGRP-1:0]  grp_full_r;

  logic [GRP_W-1:0] used_q, touch_q;
  logic             row_vld_q;
  logic [GEN_W-1:0] gen_q;
  logic [63:0]      hdl_q;

  logic [GSEL_W-1:0] grp;
  logic [BIT_W-1:0]  bit_s;
  logic [GRP_W-1:0]  used_cur, touch_cur, bit_oh;
  logic [GEN_W-1:0]  gen_cur;
  logic [KEY_BITS-1:0] slot_key;
  logic              key_match;

  logic [GSEL_W-1:0] grp_sel;
  logic              grp_found;
  logic [BIT_W-1:0]  bit_sel;

  logic              row_we, gen_we, hdl_we, full_upd;
  logic [GRP_W-1:0]  used_wd, touch_wd;
  out_word_t         res;
  out_word_t         out_data_r;

  assign grp   = GSEL_W'(idx_r >> BIT_W);
  assign bit_s = idx_r[BIT_W-1:0];

  // rows never written since reset read as zero
  assign used_cur  = row_vld_q ? used_q  : '0;
  assign touch_cur = row_vld_q ? touch_q : '0;
  assign gen_cur   = touch_cur[bit_s] ? gen_q : '0;
  assign bit_oh    = GRP_W'(1) << bit_s;
  assign slot_key  = {gen_cur, idx_r};
  assign key_match = used_cur[bit_s] && (CMP_W'(key_r) == CMP_W'(slot_key));

  // lowest group with a free slot
  always_comb begin
    grp_sel   = '0;
    grp_found = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!grp_full_r[g]) begin
        grp_sel   = GSEL_W'(g);
        grp_found = 1'b1;
      end
    end
  end

  // lowest free slot inside the chosen row
  always_comb begin
    bit_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!used_cur[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
  end

  always_comb begin
    row_we   = 1'b0;
    gen_we   = 1'b0;
    hdl_we   = 1'b0;
    full_upd = 1'b0;
    used_wd  = used_cur;
    touch_wd = touch_cur;
    res      = '{status: ST_BADKEY, key_out: '0, handler_out: '0};
    case (op_r)
      OP_CREATE: begin
        if (found_r) begin
          row_we       = 1'b1;
          hdl_we       = 1'b1;
          full_upd     = 1'b1;
          used_wd      = used_cur | bit_oh;
          res.status   = ST_OK;
          res.key_out  = 32'(CMP_W'(slot_key));
        end else begin
          res.status   = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (key_match) begin
          row_we     = 1'b1;
          gen_we     = 1'b1;
          full_upd   = 1'b1;
          used_wd    = used_cur & ~bit_oh;
          touch_wd   = touch_cur | bit_oh;
          res.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (key_match) begin
          res.status      = ST_OK;
          res.handler_out = hdl_q;
        end
      end
      default: res.status = ST_BADKEY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.key_in;
      hdl_r <= in_data.handler_in;
      idx_r <= in_data.key_in[IDX_W-1:0];
    end else if (cmd.find) begin
      idx_r <= IDX_W'(IDX_W'(grp_sel) << BIT_W);
    end else if (cmd.pick) begin
      idx_r[BIT_W-1:0] <= bit_sel;
    end
    if (cmd.find) begin
      found_r <= grp_found;
    end
    if (cmd.exec) begin
      out_data_r <= res;
    end
  end

  // tables: free-running registered read at the current slot
  always_ff @(posedge clk) begin
    used_q    <= used_mem[grp];
    touch_q   <= touch_mem[grp];
    row_vld_q <= row_vld_r[grp];
    gen_q     <= gen_mem[idx_r];
    hdl_q     <= hdl_mem[idx_r];
    if (cmd.exec && row_we) begin
      used_mem[grp]  <= used_wd;
      touch_mem[grp] <= touch_wd;
    end
    if (cmd.exec && gen_we) begin
      gen_mem[idx_r] <= GEN_W'(gen_cur + GEN_W'(1));
    end
    if (cmd.exec && hdl_we) begin
      hdl_mem[idx_r] <= hdl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      grp_full_r <= '0;
    end else if (cmd.exec) begin
      if (row_we) begin
        row_vld_r[grp] <= 1'b1;
      end
      if (full_upd) begin
        grp_full_r[grp] <= &used_wd;
      end
    end
  end

  assign sts.is_create = (in_data.opcode == OP_CREATE);
  assign sts.grp_found = grp_found;
  assign out_data      = out_data_r;

  a_pick_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> !(&used_cur))
    else $error("picked row has no free slot");

  a_create_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op_r == OP_CREATE) && found_r) |-> !used_cur[bit_s])
    else $error("create claims a slot in use");

  a_delete_frees_group: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op_r == OP_DELETE) && key_match) |=> !grp_full_r[$past(grp)])
    else $error("group still full after delete");

endmodule

### hdl/generation_tagged_slot_allocator_top.sv
// Channel | Ports                          | Direction | Word
// input   | in_valid, in_stall, in_data    | in        | in_word_t (opcode, key, handler)
// result  | out_valid, out_stall, out_data | out       | out_word_t (status, key, handler)
//
// One word in, one result word out. After acceptance a create runs group search, row read, slot
// pick, slot read and execute; a create on a full table runs group search and execute; delete,
// lookup and unused opcodes run slot read and execute. A new word is taken the cycle after the
// result is loaded. Reset (rst_n low, synchronous) empties the table at once through per-row
// valid bits. A stalled result holds in the output register; execute waits only while that
// register is full and stalled. SLOTS must be a power of two.
module generation_tagged_slot_allocator_top
  import gtsa_pkg::*;
#(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  gtsa_cmd_t cmd;
  gtsa_sts_t sts;

  // sequence each word: latch, search, read, execute, hold result
  gtsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot tables, free-slot search, key check and result register
  gtsa_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
